// ----- hdl/brg_pkg.sv -----
// brg_pkg: shared constants, request/result structs, codes and the
// controller/datapath interface structs for the exp-golomb bit reader.
// no dependencies.
`default_nettype none

package brg_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int SEEK_W      = 13;
    localparam int WIDTH_W     = 6;
    localparam int HOLD_W      = 40;
    localparam int HELD_W      = 6;
    localparam int BL_W        = CNT_W + 4;
    localparam int CMP_W       = (CNT_W > SEEK_W) ? CNT_W : SEEK_W;
    localparam int BYTE_BITS   = 8;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         byte_value;
        logic [WIDTH_W-1:0] bit_width;
        logic [SEEK_W-1:0]  seek_position;
    } t_request;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_UE     = 3'd3,
        OP_SE     = 3'd4,
        OP_SEEK   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_PREFIX = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_BITS = 2'd1,
        RES_UE   = 2'd2,
        RES_SE   = 2'd3
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_FILL     = 3'd2,
        S_SCAN     = 3'd3,
        S_SUFFIX   = 3'd4
    } t_state;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    seek;
        logic    clear;
        logic    fetch;
        logic    scan;
        logic    consume;
        logic    emit;
        logic    no_suffix;
        t_res    kind;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       rd_bad;
        logic       short_bits;
        logic       have;
        logic       need_fetch;
        logic       pend;
        logic       held_zero;
        logic       more_bytes;
        logic       scan_hit;
        logic       left_zero;
        logic       want_big;
        logic       want_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/bit_reader_exp_golomb.sv -----
// bit_reader_exp_golomb: top level of the msb-first bitstream reader with
// order-0 exp-golomb decode. instantiates brg_ctrl and brg_datapath; uses brg_pkg.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown on o_result with o_strobe high for a single cycle.
// The receiver cannot stall, so results must be taken when strobed; the next
// request may be issued in the strobe cycle. Append, seek, clear, unused codes
// and rejected reads are answered from the dispatch state. A read or peek goes
// on to the fill state, which pulls bytes from the 4096-byte store into the
// holding window until the requested bits are held. A ue/se decode scans the
// prefix up to 8 held bits per cycle, and refills one byte at a time from the
// store while no bits are held; the suffix state then checks the prefix, and
// the suffix then loads like a read. The store has a single registered read
// port. The store is not cleared after reset; only appended bytes are ever
// read.
`default_nettype none

module bit_reader_exp_golomb (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire brg_pkg::t_request i_request,
    output logic                   busy,
    output logic                   o_strobe,
    output brg_pkg::t_result       o_result
);

    brg_pkg::t_dp_cmd  cmd;
    brg_pkg::t_dp_stat stat;

    brg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    brg_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_request (i_request),
        .o_stat    (stat),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ----- hdl/brg_datapath.sv -----
// brg_datapath: byte store, read pointers, bit holding window, zero scan
// and result formatting. driven by brg_ctrl commands; uses brg_pkg.
`default_nettype none

module brg_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire brg_pkg::t_dp_cmd i_cmd,
    input  wire brg_pkg::t_request i_request,
    output brg_pkg::t_dp_stat     o_stat,
    output brg_pkg::t_result      o_result
);

    logic [7:0] r_mem [brg_pkg::STORE_BYTES];
    logic [7:0] r_rdata;
    logic       r_rvalid;
    logic       n_rvalid;

    logic [brg_pkg::CNT_W-1:0]   r_count, n_count;
    logic [brg_pkg::CNT_W-1:0]   r_next, n_next;
    logic [brg_pkg::HOLD_W-1:0]  r_hold, n_hold;
    logic [brg_pkg::HELD_W-1:0]  r_held, n_held;
    logic [brg_pkg::WIDTH_W-1:0] r_want, n_want;

    logic [2:0]                 r_op;
    logic [7:0]                 r_byte;
    logic [brg_pkg::SEEK_W-1:0] r_seek;
    brg_pkg::t_result           r_result;

    logic                      full;
    logic [brg_pkg::BL_W-1:0]  bits_left;
    logic [brg_pkg::CNT_W-1:0] seek_target;

    // zero scan over the top byte of the holding window
    logic [brg_pkg::HOLD_W-1:0] win;
    logic [7:0]                 win8;
    logic [3:0]                 nv;
    logic [7:0]                 vmask;
    logic [3:0]                 lz;
    logic                       seen;
    logic                       hit;
    logic [3:0]                 zadd;
    logic [brg_pkg::HELD_W-1:0] zused;
    logic [6:0]                 zsum;

    logic [brg_pkg::HELD_W-1:0] sh;
    logic [31:0]                bits;
    logic [31:0]                suffix;
    logic [31:0]                u;
    logic [31:0]                mag;
    logic [31:0]                res_value;

    assign full      = (r_count == brg_pkg::CNT_W'(brg_pkg::STORE_BYTES));
    assign bits_left = {1'b0, (r_count - r_next), 3'b000} + brg_pkg::BL_W'(r_held);
    assign seek_target = (brg_pkg::CMP_W'(r_seek) < brg_pkg::CMP_W'(r_count)) ?
                         brg_pkg::CNT_W'(r_seek) : r_count;

    always_comb begin
        win   = (r_held >= 6'd8) ? (r_hold >> (r_held - 6'd8)) : (r_hold << (6'd8 - r_held));
        nv    = (r_held >= 6'd8) ? 4'd8 : r_held[3:0];
        vmask = 8'hFF << (4'd8 - nv);
        win8  = win[7:0] & vmask;
        lz    = 4'd0;
        seen  = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!seen) begin
                if (win8[i]) begin
                    seen = 1'b1;
                end else begin
                    lz = lz + 4'd1;
                end
            end
        end
        hit   = (win8 != 8'd0);
        zadd  = hit ? lz : nv;
        zused = hit ? ({2'b00, lz} + 6'd1) : {2'b00, nv};
        zsum  = {1'b0, r_want} + {3'b000, zadd};
    end

    // bit extraction and code formatting
    always_comb begin
        sh        = r_held - r_want;
        bits      = 32'(r_hold >> sh) & ~(32'hFFFF_FFFF << r_want);
        suffix    = i_cmd.no_suffix ? 32'd0 : bits;
        u         = (32'd1 << r_want[4:0]) | suffix;
        mag       = {1'b0, u[31:1]};
        res_value = 32'd0;
        case (i_cmd.kind)
            brg_pkg::RES_ZERO: res_value = 32'd0;
            brg_pkg::RES_BITS: res_value = bits;
            brg_pkg::RES_UE:   res_value = u - 32'd1;
            brg_pkg::RES_SE:   res_value = u[0] ? (32'd0 - mag) : mag;
            default:           res_value = 32'd0;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_next   = r_next;
        n_hold   = r_hold;
        n_held   = r_held;
        n_want   = r_want;
        n_rvalid = i_cmd.fetch;
        if (r_rvalid) begin
            n_hold = {r_hold[brg_pkg::HOLD_W-9:0], r_rdata};
            n_held = r_held + 6'd8;
        end
        if (i_cmd.fetch) begin
            n_next = r_next + 1'b1;
        end
        if (i_cmd.append && !full) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.scan) begin
            n_held = r_held - zused;
            n_want = (zsum > 7'd32) ? 6'd32 : zsum[5:0];
        end
        if (i_cmd.consume) begin
            n_held = r_held - r_want;
        end
        if (i_cmd.seek) begin
            n_next = seek_target;
            n_held = '0;
        end
        if (i_cmd.clear) begin
            n_count = '0;
            n_next  = '0;
            n_held  = '0;
        end
        if (i_cmd.load) begin
            if (i_request.operation == brg_pkg::OP_UE ||
                i_request.operation == brg_pkg::OP_SE) begin
                n_want = '0;
            end else begin
                n_want = i_request.bit_width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_next   <= '0;
            r_held   <= '0;
            r_want   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_next   <= n_next;
            r_held   <= n_held;
            r_want   <= n_want;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (i_cmd.load) begin
            r_op   <= i_request.operation;
            r_byte <= i_request.byte_value;
            r_seek <= i_request.seek_position;
        end
        if (i_cmd.emit) begin
            r_result.value  <= res_value;
            r_result.status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem[r_count[brg_pkg::ADDR_W-1:0]] <= r_byte;
        end
        if (i_cmd.fetch) begin
            r_rdata <= r_mem[r_next[brg_pkg::ADDR_W-1:0]];
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.full       = full;
        o_stat.rd_bad     = (r_want == 6'd0) || (r_want > 6'd32);
        o_stat.short_bits = (bits_left < brg_pkg::BL_W'(r_want));
        o_stat.have       = (r_held >= r_want);
        o_stat.need_fetch = (({1'b0, r_held} + (r_rvalid ? 7'd8 : 7'd0)) < {1'b0, r_want});
        o_stat.pend       = r_rvalid;
        o_stat.held_zero  = (r_held == 6'd0);
        o_stat.more_bytes = (r_next < r_count);
        o_stat.scan_hit   = hit;
        o_stat.left_zero  = (bits_left == '0);
        o_stat.want_big   = (r_want > 6'd31);
        o_stat.want_zero  = (r_want == 6'd0);
    end

    assign o_result = r_result;

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= r_count)
        else $error("read pointer past loaded byte count");

    a_fetch_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch |-> (r_next < r_count))
        else $error("fetch of a byte never appended");

    a_consume_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.consume |-> (r_held >= r_want && !r_rvalid))
        else $error("consume of bits not yet in holding window");

    a_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid |-> (r_held <= 6'(brg_pkg::HOLD_W - 8)))
        else $error("byte capture would overflow holding window");

endmodule

`default_nettype wire

// ----- hdl/brg_ctrl.sv -----
// brg_ctrl: request sequencer for the exp-golomb bit reader; issues
// datapath commands and the result strobe. uses brg_pkg.
`default_nettype none

module brg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire brg_pkg::t_dp_stat i_stat,
    output brg_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy,
    output logic                   o_strobe
);

    brg_pkg::t_state r_state, n_state;
    logic            r_strobe;

    always_comb begin
        n_state = r_state;
        case (r_state)
            brg_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = brg_pkg::S_DISPATCH;
                end
            end
            brg_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    brg_pkg::OP_READ, brg_pkg::OP_PEEK: begin
                        n_state = (i_stat.rd_bad || i_stat.short_bits) ?
                                  brg_pkg::S_IDLE : brg_pkg::S_FILL;
                    end
                    brg_pkg::OP_UE, brg_pkg::OP_SE: n_state = brg_pkg::S_SCAN;
                    default: n_state = brg_pkg::S_IDLE;
                endcase
            end
            brg_pkg::S_FILL: begin
                if (i_stat.have) begin
                    n_state = brg_pkg::S_IDLE;
                end
            end
            brg_pkg::S_SCAN: begin
                if (i_stat.held_zero) begin
                    if (!i_stat.pend && !i_stat.more_bytes) begin
                        n_state = brg_pkg::S_IDLE;
                    end
                end else if (i_stat.scan_hit) begin
                    n_state = brg_pkg::S_SUFFIX;
                end
            end
            brg_pkg::S_SUFFIX: begin
                if (i_stat.left_zero || i_stat.want_big || i_stat.want_zero ||
                    i_stat.short_bits) begin
                    n_state = brg_pkg::S_IDLE;
                end else begin
                    n_state = brg_pkg::S_FILL;
                end
            end
            default: n_state = brg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = brg_pkg::RES_ZERO;
        o_cmd.status = brg_pkg::ST_OK;
        case (r_state)
            brg_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            brg_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    brg_pkg::OP_APPEND: begin
                        o_cmd.append = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = i_stat.full ? brg_pkg::ST_FULL : brg_pkg::ST_OK;
                    end
                    brg_pkg::OP_READ, brg_pkg::OP_PEEK: begin
                        if (i_stat.rd_bad || i_stat.short_bits) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = brg_pkg::ST_SHORT;
                        end
                    end
                    brg_pkg::OP_UE, brg_pkg::OP_SE: begin
                        o_cmd.emit = 1'b0;
                    end
                    brg_pkg::OP_SEEK: begin
                        o_cmd.seek = 1'b1;
                        o_cmd.emit = 1'b1;
                    end
                    brg_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.emit  = 1'b1;
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                    end
                endcase
            end
            brg_pkg::S_FILL: begin
                if (i_stat.have) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.consume = (i_stat.op != brg_pkg::OP_PEEK);
                    case (i_stat.op)
                        brg_pkg::OP_UE: o_cmd.kind = brg_pkg::RES_UE;
                        brg_pkg::OP_SE: o_cmd.kind = brg_pkg::RES_SE;
                        default:        o_cmd.kind = brg_pkg::RES_BITS;
                    endcase
                end else begin
                    o_cmd.fetch = i_stat.need_fetch;
                end
            end
            brg_pkg::S_SCAN: begin
                if (i_stat.held_zero) begin
                    // refill one byte at a time while hunting for the one bit
                    if (!i_stat.pend) begin
                        if (i_stat.more_bytes) begin
                            o_cmd.fetch = 1'b1;
                        end else begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = brg_pkg::ST_SHORT;
                        end
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            brg_pkg::S_SUFFIX: begin
                if (i_stat.left_zero) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = brg_pkg::ST_SHORT;
                end else if (i_stat.want_big) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = brg_pkg::ST_PREFIX;
                end else if (i_stat.want_zero) begin
                    o_cmd.emit = 1'b1;
                end else if (i_stat.short_bits) begin
                    // suffix cut short: code taken with an all-zero suffix
                    o_cmd.emit      = 1'b1;
                    o_cmd.no_suffix = 1'b1;
                    o_cmd.status    = brg_pkg::ST_SHORT;
                    o_cmd.kind      = (i_stat.op == brg_pkg::OP_SE) ?
                                      brg_pkg::RES_SE : brg_pkg::RES_UE;
                end
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brg_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_cmd.emit;
        end
    end

    assign o_busy   = (r_state != brg_pkg::S_IDLE);
    assign o_strobe = r_strobe;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_strobe)
        else $error("result strobe in the cycle after a request was taken");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !o_busy)
        else $error("controller still busy after emitting a result");

endmodule

`default_nettype wire
